/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg
// Widths, character codes and the handoff type of the integer-to-text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_WIDTH = 32;

    // Number of decimal digits of 2**exp, worked out at elaboration
    function automatic int dec_digits_pow2(input int exp);
        logic [63:0] v;
        int          n;
        v = 64'd1 << exp;
        n = 0;
        for (int i = 0; i < 21; i++)
        begin
            if (v != 64'd0)
            begin
                v = v / 64'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int DIGITS      = dec_digits_pow2(VALUE_WIDTH - 1);
    localparam int BCD_W       = 4 * DIGITS;
    localparam int SHIFT_CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W      = $clog2(DIGITS + 1);

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    // Converted number handed from the BCD converter to the character emitter
    typedef struct packed {
        logic             valid;
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } bcd_word_t;

endpackage

/* rtl/sitda_value_if.sv */
// ----------------------------------------------------------------------------
// sitda_value_if
// Input channel: one signed integer per word.
// ----------------------------------------------------------------------------
interface sitda_value_if;
    import sitda_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* rtl/sitda_char_if.sv */
// ----------------------------------------------------------------------------
// sitda_char_if
// Output channel: one ASCII character per word with a last marker.
// ----------------------------------------------------------------------------
interface sitda_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] text_char;
    logic       is_last;

    modport source (output valid, output text_char, output is_last, input ready);
    modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

/* rtl/sitda_bcd_conv.sv */
// ----------------------------------------------------------------------------
// sitda_bcd_conv
// Takes the magnitude of a signed integer and turns it into packed BCD by
// serial shift-and-add-3, one bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitda_bcd_conv (
    input  logic                 clk,
    input  logic                 rst_n,
    sitda_value_if.sink          number,
    output sitda_pkg::bcd_word_t bcd_out,
    input  logic                 bcd_ready
);
    import sitda_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_SHIFT = 3'b010,
        C_DONE  = 3'b100
    } conv_state_t;

    conv_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [SHIFT_CNT_W-1:0] cnt_reg, cnt_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic [BCD_W-1:0]       bcd_adj;

    assign raw = $unsigned(number.value);

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (number.valid)
                begin
                    neg_next   = raw[VALUE_WIDTH-1];
                    mag_next   = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + 1'b1) : raw;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = C_SHIFT;
                end
            end
            C_SHIFT:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next = mag_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SHIFT_CNT_W'(VALUE_WIDTH - 1))
                    state_next = C_DONE;
            end
            C_DONE:
            begin
                // hold until the emitter takes the word
                if (bcd_ready)
                    state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    assign number.ready     = (state_reg == C_IDLE);
    assign bcd_out.valid    = (state_reg == C_DONE);
    assign bcd_out.negative = neg_reg;
    assign bcd_out.bcd      = bcd_reg;

    `ASSERT_SAME(a_shift_count, clk, rst_n, state_reg == C_SHIFT,
        cnt_reg < SHIFT_CNT_W'(VALUE_WIDTH), "shift count ran past the value width")
    `ASSERT_SAME(a_done_count, clk, rst_n, state_reg == C_DONE,
        cnt_reg == SHIFT_CNT_W'(VALUE_WIDTH), "BCD word offered before all bits shifted")
    `ASSERT_NEXT(a_done_release, clk, rst_n, state_reg == C_DONE && bcd_ready,
        state_reg == C_IDLE, "converter did not release after handoff")

endmodule

/* rtl/sitda_char_emit.sv */
// ----------------------------------------------------------------------------
// sitda_char_emit
// Walks the BCD digits from the top, drops leading zeros and sends the sign
// and the digits as ASCII words through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitda_char_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sitda_pkg::bcd_word_t bcd_in,
    output logic                 bcd_ready,
    sitda_char_if.source         text
);
    import sitda_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE  = 3'b001,
        E_SIGN  = 3'b010,
        E_DIGIT = 3'b100
    } emit_state_t;

    emit_state_t      state_reg, state_next;
    logic [BCD_W-1:0] digits_reg, digits_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic             started_reg, started_next;
    logic             out_valid_reg, out_valid_next;
    logic [6:0]       char_reg, char_next;
    logic             last_reg, last_next;

    logic       slot_free;
    logic       load;
    logic [3:0] top;

    assign slot_free = !out_valid_reg || text.ready;
    assign top       = digits_reg[BCD_W-1 -: 4];
    assign bcd_ready = (state_reg == E_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        digits_next  = digits_reg;
        left_next    = left_reg;
        started_next = started_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        load         = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (bcd_in.valid)
                begin
                    digits_next  = bcd_in.bcd;
                    left_next    = LEFT_W'(DIGITS);
                    started_next = 1'b0;
                    state_next   = bcd_in.negative ? E_SIGN : E_DIGIT;
                end
            end
            E_SIGN:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = E_DIGIT;
                end
            end
            E_DIGIT:
            begin
                // drop leading zeros, but always keep the units digit
                if (top == 4'd0 && !started_reg && left_reg != LEFT_W'(1))
                begin
                    digits_next = digits_reg << 4;
                    left_next   = left_reg - 1'b1;
                end
                else if (slot_free)
                begin
                    load         = 1'b1;
                    char_next    = CHAR_ZERO + {3'b000, top};
                    last_next    = (left_reg == LEFT_W'(1));
                    digits_next  = digits_reg << 4;
                    left_next    = left_reg - 1'b1;
                    started_next = 1'b1;
                    if (left_reg == LEFT_W'(1))
                        state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    assign out_valid_next = load || (out_valid_reg && !text.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg  <= digits_next;
        left_reg    <= left_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.text_char = char_reg;
    assign text.is_last   = last_reg;

    `ASSERT_SAME(a_sign_first, clk, rst_n, state_reg == E_SIGN,
        left_reg == LEFT_W'(DIGITS), "sign pending after digits started")
    `ASSERT_SAME(a_digit_left, clk, rst_n, state_reg == E_DIGIT,
        left_reg != '0, "digit walk with no digits left")
    `ASSERT_NEXT(a_last_out, clk, rst_n,
        state_reg == E_DIGIT && left_reg == LEFT_W'(1) && slot_free,
        out_valid_reg && last_reg, "units digit not sent with last marker")

endmodule

/* rtl/signed_int_to_decimal_ascii_top.sv */
// A new number goes through the serial binary-to-BCD converter, which
// shifts one bit of the magnitude per cycle. The emitter then sends a minus
// sign for a negative number and walks the 10 BCD digits, dropping leading
// zeros and sending one character per cycle, as long as the output takes
// each one, through an output register. Meanwhile the converter already
// takes and works on the next number.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed integer to decimal ASCII text, most significant character first.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
    input  logic         clk,
    input  logic         rst_n,
    sitda_value_if.sink  number,
    sitda_char_if.source text
);
    import sitda_pkg::*;

    bcd_word_t bcd_word;
    logic      bcd_ready;

    sitda_bcd_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number),
        .bcd_out   (bcd_word),
        .bcd_ready (bcd_ready)
    );

    sitda_char_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .bcd_in    (bcd_word),
        .bcd_ready (bcd_ready),
        .text      (text)
    );

endmodule
